// ===== rtl/stepper_position_servo_tick_defines.svh =====
// Assertion macros shared by the servo tick files.
// They expect signals named clk and rst in the scope where they are used.
`ifndef STEPPER_POSITION_SERVO_TICK_DEFINES_SVH
`define STEPPER_POSITION_SERVO_TICK_DEFINES_SVH

// The consequence must hold in the same cycle as the condition.
`define SPS_CHECK(lbl, cond, prop) lbl: assert property (@(posedge clk) disable iff (rst) \
  (cond) |-> (prop)) else $error("servo tick check failed");

// The consequence must hold in the cycle after the condition.
`define SPS_CHECK_NEXT(lbl, cond, prop) lbl: assert property (@(posedge clk) disable iff (rst) \
  (cond) |=> (prop)) else $error("servo tick check failed");

`endif

// ===== rtl/sps_pkg.sv =====
package sps_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_LAP_COUNTS   = 51200;
  localparam int DEF_TICK_RATE_HZ = 20000;

  // Datapath widths.
  localparam int MUL_W  = 18;          // signed multiplier operand width
  localparam int PROD_W = 2 * MUL_W;   // full product width
  localparam int DIFF_W = 18;          // unwrapped angle step
  localparam int ERR_W  = 13;          // clamped position and speed errors
  localparam int INT_W  = 25;          // integral and total current sums
  localparam int CUR_W  = 13;          // drive current
  localparam int GAIN_W = 11;
  localparam int RATED_W = 12;

  // Controller constants.
  localparam int LIM_POS      = 3200;
  localparam int LIM_SPEED    = 4000;
  localparam int DRIVE_OFFSET = 80;
  localparam int SPEED_SHIFT  = 5;
  localparam int VERR_SHIFT   = 7;
  localparam int INT_SHIFT    = 7;
  localparam int OUT_SHIFT    = 10;
  localparam int GAIN_MAX     = 1024;
  localparam int RATED_RESET  = 3000;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_POSITION       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEGRAL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SPEED_INTEGRAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DAMPING        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATED_CURRENT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_MODE           = 3'd5;

  // Output codes.
  localparam logic [1:0] MODE_SLEEP = 2'd0;
  localparam logic [1:0] MODE_BRAKE = 2'd1;
  localparam logic [1:0] MODE_DRIVE = 2'd2;

  localparam logic [1:0] RUN_STOPPED = 2'd0;
  localparam logic [1:0] RUN_AT_GOAL = 2'd1;
  localparam logic [1:0] RUN_MOVING  = 2'd2;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_position;
    logic [GAIN_W-1:0]  gain_integral;
    logic [GAIN_W-1:0]  gain_speed_integral;
    logic [GAIN_W-1:0]  gain_damping;
    logic [RATED_W-1:0] rated_current;
    logic               stop_mode;
  } cfg_t;

endpackage

// ===== rtl/sps_mul.sv =====
module sps_mul import sps_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod
);

  // Registered product; the sequencer reads it in the cycle after it sets up the operands.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== rtl/sps_cfg.sv =====
module sps_cfg import sps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  logic [GAIN_W-1:0] gain;
  logic              gain_ok;

  assign gain    = wr_data[GAIN_W-1:0];
  assign gain_ok = (gain <= GAIN_W'(GAIN_MAX));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_position       <= '0;
      cfg.gain_integral       <= '0;
      cfg.gain_speed_integral <= '0;
      cfg.gain_damping        <= '0;
      cfg.rated_current       <= RATED_W'(RATED_RESET);
      cfg.stop_mode           <= 1'b0;
    end else if (wr_en) begin
      // Gain values (the low GAIN_W bits of the data) above the limit are dropped and the old value stays.
      unique case (wr_index)
        REG_GAIN_POSITION: begin
          if (gain_ok) cfg.gain_position <= gain;
        end
        REG_GAIN_INTEGRAL: begin
          if (gain_ok) cfg.gain_integral <= gain;
        end
        REG_GAIN_SPEED_INTEGRAL: begin
          if (gain_ok) cfg.gain_speed_integral <= gain;
        end
        REG_GAIN_DAMPING: begin
          if (gain_ok) cfg.gain_damping <= gain;
        end
        REG_RATED_CURRENT: begin
          cfg.rated_current <= wr_data[RATED_W-1:0];
        end
        REG_STOP_MODE: begin
          cfg.stop_mode <= wr_data[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/stepper_position_servo_tick.sv =====
// A drive tick runs DIFF, POS, SPD, PERR, VERR, I1 to I4 and FIN; a sleep or brake tick
// goes from SPD to FIN. A new tick is taken only in IDLE, after the last one left FIN; the
// first tick only seeds the position. One shared 18x18 multiplier serves five products a
// drive tick, one a sleep or brake tick. A finished result waits in the output register,
// and the next tick is taken meanwhile. Reset (synchronous, active high) restores the
// register defaults, clears the servo state, and drops any pending result.
`include "stepper_position_servo_tick_defines.svh"

module stepper_position_servo_tick import sps_pkg::*; #(
  parameter int LAP_COUNTS   = DEF_LAP_COUNTS,
  parameter int TICK_RATE_HZ = DEF_TICK_RATE_HZ
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           lap_angle,
  input  logic signed [31:0]    goal_position,
  input  logic signed [31:0]    target_speed,
  input  logic                  stall_req,
  input  logic                  soft_off,
  input  logic                  soft_stop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            drive_mode,
  output logic signed [31:0]    drive_position,
  output logic signed [12:0]    drive_current,
  output logic [1:0]            run_state,
  output logic signed [31:0]    speed_estimate,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_DIFF = 11'b00000000010,
    S_POS  = 11'b00000000100,
    S_SPD  = 11'b00000001000,
    S_PERR = 11'b00000010000,
    S_VERR = 11'b00000100000,
    S_I1   = 11'b00001000000,
    S_I2   = 11'b00010000000,
    S_I3   = 11'b00100000000,
    S_I4   = 11'b01000000000,
    S_FIN  = 11'b10000000000
  } state_t;

  localparam logic signed [DIFF_W-1:0] LAP_FULL = DIFF_W'(LAP_COUNTS);
  localparam logic signed [DIFF_W-1:0] LAP_HALF = DIFF_W'(LAP_COUNTS / 2);
  localparam logic signed [31:0]       POS_LIM  = 32'(LIM_POS);
  localparam logic signed [31:0]       SPD_LIM  = 32'(LIM_SPEED);

  cfg_t   cfg;
  state_t state, state_next;

  // Servo state.
  logic                      started;
  logic [15:0]               last_angle;
  logic [31:0]               position;
  logic [SPEED_SHIFT-1:0]    speed_rem;
  logic [31:0]               speed;
  logic [INT_SHIFT-1:0]      integ_rem;
  logic signed [INT_W-1:0]   integ_sum;

  // Latched tick inputs and working registers.
  logic [15:0]               angle_r;
  logic [31:0]               goal_p_r;
  logic [31:0]               goal_s_r;
  logic                      stall_r;
  logic                      off_r;
  logic                      stop_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [ERR_W-1:0]   perr;
  logic signed [ERR_W-1:0]   verr;
  logic signed [INT_W-1:0]   rem_acc;
  logic signed [INT_W-1:0]   total;

  // Shared multiplier.
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [INT_W-1:0]   prod_lo;

  // Combinational helpers.
  logic signed [DIFF_W-1:0]  raw_diff, diff_next;
  logic [31:0]               spd_sum;
  logic signed [31:0]        pos_err, vel_err;
  logic signed [ERR_W-1:0]   perr_next, verr_next;
  logic signed [INT_W-1:0]   step, isum, ilim, integ_next;
  logic signed [INT_W-1:0]   cur_wide, rated_wide;
  logic signed [CUR_W-1:0]   cur;
  logic signed [12:0]        rated_lim;
  logic                      cur_in_range, outputs_cleared;
  logic [1:0]                mode_next, run_next;
  logic [31:0]               dpos_next;
  logic                      in_xfer, out_load;

  sps_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sps_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_load  = (state == S_FIN) && (!out_valid || out_ready);
  assign prod_lo   = prod[INT_W-1:0];

  // Multiplier operands for the product that is consumed in the following state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_POS: begin
        mul_a = diff_r;
        mul_b = MUL_W'(TICK_RATE_HZ);
      end
      S_VERR: begin
        mul_a = MUL_W'(perr);
        mul_b = MUL_W'(cfg.gain_integral);
      end
      S_I1: begin
        mul_a = MUL_W'(verr);
        mul_b = MUL_W'(cfg.gain_speed_integral);
      end
      S_I2: begin
        mul_a = MUL_W'(perr);
        mul_b = MUL_W'(cfg.gain_position);
      end
      S_I3: begin
        mul_a = MUL_W'(verr);
        mul_b = MUL_W'(cfg.gain_damping);
      end
      default: begin
      end
    endcase
  end

  // Angle unwrap: the step is moved by at most one lap.
  always_comb begin
    raw_diff = $signed({2'b00, angle_r}) - $signed({2'b00, last_angle});
    if (raw_diff > LAP_HALF) begin
      diff_next = raw_diff - LAP_FULL;
    end else if (raw_diff < -LAP_HALF) begin
      diff_next = raw_diff + LAP_FULL;
    end else begin
      diff_next = raw_diff;
    end
  end

  // Speed filter: sum of the step times the tick rate, 31 times the old estimate and the remainder.
  assign spd_sum = 32'(speed_rem) + prod[31:0] + ({speed[31-SPEED_SHIFT:0], {SPEED_SHIFT{1'b0}}}
                   - speed);

  always_comb begin
    pos_err = $signed(goal_p_r - position);
    if (pos_err > POS_LIM) begin
      perr_next = ERR_W'(LIM_POS);
    end else if (pos_err < -POS_LIM) begin
      perr_next = -ERR_W'(LIM_POS);
    end else begin
      perr_next = pos_err[ERR_W-1:0];
    end

    vel_err = $signed(goal_s_r - speed) >>> VERR_SHIFT;
    if (vel_err > SPD_LIM) begin
      verr_next = ERR_W'(LIM_SPEED);
    end else if (vel_err < -SPD_LIM) begin
      verr_next = -ERR_W'(LIM_SPEED);
    end else begin
      verr_next = vel_err[ERR_W-1:0];
    end
  end

  // Integral update: whole steps leave the remainder, the sum is clamped to rated << 10.
  always_comb begin
    step = rem_acc >>> INT_SHIFT;
    isum = integ_sum + step;
    ilim = INT_W'({cfg.rated_current, {OUT_SHIFT{1'b0}}});
    if (isum > ilim) begin
      integ_next = ilim;
    end else if (isum < -ilim) begin
      integ_next = -ilim;
    end else begin
      integ_next = isum;
    end
  end

  // Result assembly.
  always_comb begin
    rated_wide = INT_W'(cfg.rated_current);
    cur_wide   = total >>> OUT_SHIFT;
    if (cur_wide > rated_wide) begin
      cur = CUR_W'(rated_wide);
    end else if (cur_wide < -rated_wide) begin
      cur = CUR_W'(-rated_wide);
    end else begin
      cur = cur_wide[CUR_W-1:0];
    end

    if (cur > 0) begin
      dpos_next = position + 32'(DRIVE_OFFSET);
    end else if (cur < 0) begin
      dpos_next = position - 32'(DRIVE_OFFSET);
    end else begin
      dpos_next = position;
    end

    if (stall_r || off_r) begin
      mode_next = MODE_SLEEP;
    end else if (stop_r) begin
      mode_next = MODE_BRAKE;
    end else begin
      mode_next = MODE_DRIVE;
    end

    if (cfg.stop_mode) begin
      run_next = RUN_STOPPED;
    end else if (position == goal_p_r && speed == '0) begin
      run_next = RUN_AT_GOAL;
    end else begin
      run_next = RUN_MOVING;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && started) state_next = S_DIFF;
      end
      S_DIFF: state_next = S_POS;
      S_POS:  state_next = S_SPD;
      S_SPD: begin
        state_next = (stall_r || off_r || stop_r) ? S_FIN : S_PERR;
      end
      S_PERR: state_next = S_VERR;
      S_VERR: state_next = S_I1;
      S_I1:   state_next = S_I2;
      S_I2:   state_next = S_I3;
      S_I3:   state_next = S_I4;
      S_I4:   state_next = S_FIN;
      S_FIN: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      started    <= 1'b0;
      last_angle <= '0;
      position   <= '0;
      speed_rem  <= '0;
      speed      <= '0;
      integ_rem  <= '0;
      integ_sum  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          // The first tick only seeds the position.
          if (in_xfer && !started) begin
            started    <= 1'b1;
            last_angle <= lap_angle;
            position   <= 32'(lap_angle);
          end
        end
        S_DIFF: last_angle <= angle_r;
        S_POS:  position <= position + 32'(diff_r);
        S_SPD: begin
          speed     <= 32'($signed(spd_sum) >>> SPEED_SHIFT);
          speed_rem <= spd_sum[SPEED_SHIFT-1:0];
        end
        S_I3: begin
          integ_rem <= rem_acc[INT_SHIFT-1:0];
          integ_sum <= integ_next;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      angle_r  <= lap_angle;
      goal_p_r <= goal_position;
      goal_s_r <= target_speed;
      stall_r  <= stall_req;
      off_r    <= soft_off;
      stop_r   <= soft_stop;
    end
    if (state == S_DIFF) diff_r <= diff_next;
    if (state == S_PERR) perr <= perr_next;
    if (state == S_VERR) verr <= verr_next;
    if (state == S_I1) rem_acc <= INT_W'(integ_rem) + prod_lo;
    if (state == S_I2) rem_acc <= rem_acc + prod_lo;
    if (state == S_I3) total <= prod_lo;
    if (state == S_I4) total <= total + integ_sum + prod_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive_mode     <= mode_next;
      run_state      <= run_next;
      speed_estimate <= speed;
      if (mode_next == MODE_DRIVE) begin
        drive_position <= dpos_next;
        drive_current  <= cur;
      end else begin
        drive_position <= '0;
        drive_current  <= '0;
      end
    end
  end

  assign rated_lim       = {1'b0, cfg.rated_current};
  assign cur_in_range    = (drive_current <= rated_lim) && (drive_current >= -rated_lim);
  assign outputs_cleared = (drive_position == '0) && (drive_current == '0);

  `SPS_CHECK(a_cur_limit, out_valid && drive_mode == MODE_DRIVE, cur_in_range)
  `SPS_CHECK(a_idle_zero, out_valid && drive_mode != MODE_DRIVE, outputs_cleared)
  `SPS_CHECK_NEXT(a_seed, in_xfer && !started, state == S_IDLE && started)

endmodule
